/* src/cnp_pkg.sv */
// Shared types, constants and helper functions for the cpio newc entry parser.
// Depends on nothing; every other file of the block imports it.
package cnp_pkg;

  localparam logic [6:0] HDR_LEN     = 7'd110;
  localparam logic [6:0] HDR_LAST    = 7'd109;
  localparam logic [6:0] MAGIC_LEN   = 7'd6;
  localparam logic [6:0] FSIZE_FIRST = 7'd54;
  localparam logic [6:0] FSIZE_LAST  = 7'd61;
  localparam logic [6:0] NSIZE_FIRST = 7'd94;
  localparam logic [6:0] NSIZE_LAST  = 7'd101;

  // Header bytes after the name size digits, used to prepare the entry sums.
  localparam logic [6:0] PRE_NAME_END = 7'd102;
  localparam logic [6:0] PRE_DOFF     = 7'd103;
  localparam logic [6:0] PRE_DATA_END = 7'd104;
  localparam logic [6:0] PRE_SKIP_END = 7'd105;
  localparam logic [6:0] PRE_SKIP_REM = 7'd106;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_NAME   = 2'd1,
    PH_SKIP   = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_DESC  = 2'd1,
    KIND_END   = 2'd2,
    KIND_TRUNC = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  name_char;
    logic [31:0] data_offset;
    logic [31:0] file_length;
    logic [31:0] name_length;
    logic        last_of_run;
  } result_t;

  function automatic result_t make_result(input kind_t k, input logic [7:0] ch,
                                          input logic [31:0] doff,
                                          input logic [31:0] flen,
                                          input logic [31:0] nlen);
    result_t r;
    r.kind        = k;
    r.name_char   = ch;
    r.data_offset = doff;
    r.file_length = flen;
    r.name_length = nlen;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // A character that is not a hex digit counts as zero.
  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
    end
    return t[3:0];
  endfunction

  // Expected header magic "070701".
  function automatic logic [7:0] magic_byte(input logic [2:0] i);
    logic [7:0] m;
    unique case (i)
      3'd0:    m = 8'h30;
      3'd1:    m = 8'h37;
      3'd2:    m = 8'h30;
      3'd3:    m = 8'h37;
      3'd4:    m = 8'h30;
      3'd5:    m = 8'h31;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

/* src/cpio_newc_entry_parser.sv */
// Top level of the cpio newc entry parser: input register, archive length
// register, walker and result queue. Depends on cnp_pkg and its submodules.
// Each result passes through the input register and the result queue before
// it is offered. Throughput: one byte per cycle; in_stall rises only while the
// four-entry result queue cannot take two more results, as when beats go unread.
// Reset (rst, synchronous): walk restarts at offset zero, archive length is 0.
module cpio_newc_entry_parser import cnp_pkg::*; #(
  parameter int OFFSET_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  name_char,
  output logic [31:0] data_offset,
  output logic [31:0] file_length,
  output logic [31:0] name_length,
  output logic        last_of_run
);

  logic [31:0] arc_len;
  logic        in_full;
  logic        mode_q;
  logic [7:0]  byte_q;
  logic        room2;
  logic        process;
  logic [1:0]  push_count;
  result_t     res0, res1, out_data;

  assign process  = in_full && room2;
  assign in_stall = in_full && !room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      arc_len <= '0;
      in_full <= 1'b0;
    end else begin
      if (cfg_we) begin
        arc_len <= cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (process) begin
        in_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      mode_q <= mode;
      byte_q <= byte_value;
    end
  end

  cnp_walker #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .process    (process),
    .mode       (mode_q),
    .byte_value (byte_q),
    .arc_len    (arc_len),
    .push_count (push_count),
    .res0       (res0),
    .res1       (res1)
  );

  cnp_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push_data0 (res0),
    .push_data1 (res1),
    .room2      (room2),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign kind        = out_data.kind;
  assign name_char   = out_data.name_char;
  assign data_offset = out_data.data_offset;
  assign file_length = out_data.file_length;
  assign name_length = out_data.name_length;
  assign last_of_run = out_data.last_of_run;

endmodule

/* src/cnp_walker.sv */
// Walk state of the archive and the per-beat decision logic for one byte.
// Depends on cnp_pkg.
module cnp_walker import cnp_pkg::*; #(
  parameter int OFFSET_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        process,
  input  logic        mode,
  input  logic [7:0]  byte_value,
  input  logic [31:0] arc_len,
  output logic [1:0]  push_count,
  output result_t     res0,
  output result_t     res1
);

  localparam int SW = OFFSET_WIDTH + 2;
  localparam int CW = (SW > 32) ? SW : 32;

  phase_t         phase, phase_next;
  logic [SW-1:0]  off, off_next;
  logic [SW-1:0]  rem, rem_next;
  logic [6:0]     idx, idx_next;
  logic [31:0]    nacc, nacc_next;
  logic [31:0]    facc, facc_next;

  // Entry sums prepared during the tail of the header.
  logic [SW-1:0]  hdr_end_r, name_end_r, doff_r, data_end_r, skip_end_r, skip_rem_r;

  logic [SW-1:0]  hdr_end, off_inc, rem_dec, doff_sum, skip_sum;
  logic [CW-1:0]  as_w;
  logic [1:0]     n;
  result_t        r0;

  assign hdr_end  = off + SW'(HDR_LEN);
  assign off_inc  = off + SW'(1);
  assign rem_dec  = rem - SW'(1);
  assign doff_sum = name_end_r + SW'(3);
  assign skip_sum = data_end_r + SW'(3);
  assign as_w     = CW'(arc_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      off   <= '0;
      rem   <= '0;
      idx   <= '0;
      nacc  <= '0;
      facc  <= '0;
    end else if (process) begin
      phase <= phase_next;
      off   <= off_next;
      rem   <= rem_next;
      idx   <= idx_next;
      nacc  <= nacc_next;
      facc  <= facc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (process && !mode && phase == PH_HEADER) begin
      if (idx == '0) begin
        hdr_end_r <= hdr_end;
      end
      if (idx == PRE_NAME_END) begin
        name_end_r <= hdr_end_r + SW'(nacc);
      end
      if (idx == PRE_DOFF) begin
        doff_r <= {doff_sum[SW-1:2], 2'b00};
      end
      if (idx == PRE_DATA_END) begin
        data_end_r <= doff_r + SW'(facc);
      end
      if (idx == PRE_SKIP_END) begin
        skip_end_r <= {skip_sum[SW-1:2], 2'b00};
      end
      if (idx == PRE_SKIP_REM) begin
        skip_rem_r <= skip_end_r - name_end_r;
      end
    end
  end

  always_comb begin
    phase_next = phase;
    off_next   = off;
    rem_next   = rem;
    idx_next   = idx;
    nacc_next  = nacc;
    facc_next  = facc;
    n          = 2'd0;
    r0         = make_result(KIND_END, 8'h00, 32'h0, 32'h0, 32'h0);
    if (mode) begin
      phase_next = PH_HEADER;
      off_next   = '0;
      rem_next   = '0;
      idx_next   = '0;
      nacc_next  = '0;
      facc_next  = '0;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          if (idx == '0 && CW'(off) >= as_w) begin
            n          = 2'd1;
            phase_next = PH_DONE;
          end else if (idx == '0 && CW'(hdr_end) > as_w) begin
            r0.kind    = KIND_TRUNC;
            n          = 2'd1;
            phase_next = PH_DONE;
          end else if (idx < MAGIC_LEN && byte_value != magic_byte(idx[2:0])) begin
            n          = 2'd1;
            phase_next = PH_DONE;
          end else begin
            if (idx >= FSIZE_FIRST && idx <= FSIZE_LAST) begin
              facc_next = {facc[27:0], hex_digit(byte_value)};
            end
            if (idx >= NSIZE_FIRST && idx <= NSIZE_LAST) begin
              nacc_next = {nacc[27:0], hex_digit(byte_value)};
            end
            off_next = off_inc;
            idx_next = idx + 7'd1;
            if (idx == HDR_LAST) begin
              idx_next = '0;
              if (CW'(name_end_r) > as_w || CW'(data_end_r) > as_w) begin
                r0.kind    = KIND_TRUNC;
                n          = 2'd1;
                phase_next = PH_DONE;
              end else begin
                r0 = make_result(KIND_DESC, 8'h00, 32'(doff_r), facc, nacc);
                n  = 2'd1;
                if (nacc == '0) begin
                  // Empty name: the skip is entered on this same beat.
                  if (CW'(name_end_r) >= as_w) begin
                    n          = 2'd2;
                    phase_next = PH_DONE;
                  end else if (skip_rem_r == '0) begin
                    phase_next = PH_HEADER;
                    rem_next   = '0;
                    nacc_next  = '0;
                    facc_next  = '0;
                  end else begin
                    phase_next = PH_SKIP;
                    rem_next   = skip_rem_r;
                  end
                end else begin
                  phase_next = PH_NAME;
                  rem_next   = SW'(nacc);
                end
              end
            end
          end
        end
        PH_NAME: begin
          r0       = make_result(KIND_NAME, byte_value, 32'h0, 32'h0, 32'h0);
          n        = 2'd1;
          off_next = off_inc;
          rem_next = rem_dec;
          if (rem_dec == '0) begin
            // The last name byte lands the offset on the prepared name end.
            if (CW'(name_end_r) >= as_w) begin
              n          = 2'd2;
              phase_next = PH_DONE;
            end else if (skip_rem_r == '0) begin
              phase_next = PH_HEADER;
              rem_next   = '0;
              nacc_next  = '0;
              facc_next  = '0;
            end else begin
              phase_next = PH_SKIP;
              rem_next   = skip_rem_r;
            end
          end
        end
        PH_SKIP: begin
          off_next = off_inc;
          rem_next = rem_dec;
          if (CW'(off_inc) >= as_w) begin
            n          = 2'd1;
            phase_next = PH_DONE;
          end else if (rem_dec == '0) begin
            phase_next = PH_HEADER;
            rem_next   = '0;
            idx_next   = '0;
            nacc_next  = '0;
            facc_next  = '0;
          end
        end
        PH_DONE: begin
          phase_next = PH_DONE;
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end
  end

  always_comb begin
    res0             = r0;
    res0.last_of_run = (n == 2'd1);
    res1             = make_result(KIND_END, 8'h00, 32'h0, 32'h0, 32'h0);
    res1.last_of_run = 1'b1;
    push_count       = process ? n : 2'd0;
  end

  a_rewind_clears: assert property (@(posedge clk) disable iff (rst)
    process && mode |=> phase == PH_HEADER && off == '0 && idx == '0)
    else $error("rewind did not restore the walk state");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= HDR_LAST)
    else $error("header index ran past the header");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push_count == 2'd2 |-> res0.kind == KIND_DESC || res0.kind == KIND_NAME)
    else $error("two results on one beat without a descriptor or name byte first");

endmodule

/* src/cnp_result_fifo.sv */
// Four-entry result queue between the walker and the output channel.
// Takes up to two results per beat; depends on cnp_pkg.
module cnp_result_fifo import cnp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  result_t    push_data0,
  input  result_t    push_data1,
  output logic       room2,
  output logic       out_valid,
  input  logic       out_stall,
  output result_t    out_data
);

  localparam logic [2:0] DEPTH = 3'd4;

  result_t     entries [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  cnt, cnt_next, cnt_after;
  logic        pop;

  assign out_valid = (cnt != 3'd0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign cnt_after = cnt - {2'b00, pop};
  assign room2     = (cnt_after <= 3'd2);
  assign cnt_next  = cnt_after + {1'b0, push_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      cnt    <= cnt_next;
      wr_ptr <= wr_ptr + push_count;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push_data0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + 2'd1] <= push_data1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= DEPTH)
    else $error("result queue over-filled");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push_count != 2'd0 |-> room2)
    else $error("results pushed without room for two");

endmodule
